@@ design/sip_pkg.sv @@
// ----------------------------------------------------------------------------
// sip_pkg
// shared types and constants of the sample interval qualifier
// ----------------------------------------------------------------------------
package sip_pkg;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 64;

   localparam logic [1:0] REG_EXPECTED_CHANNEL = 2'd0;
   localparam logic [1:0] REG_NOMINAL_INTERVAL = 2'd1;
   localparam logic [1:0] REG_CAL_VERSION      = 2'd2;

   localparam logic [63:0] NOMINAL_RESET = 64'd1000;

   localparam logic OP_SAMPLE  = 1'b0;
   localparam logic OP_TIMEOUT = 1'b1;

   localparam logic [2:0] CLASS_NONE    = 3'd0;
   localparam logic [2:0] CLASS_INVALID = 3'd1;
   localparam logic [2:0] CLASS_GAP     = 3'd2;
   localparam logic [2:0] CLASS_STALE   = 3'd3;

   // configuration seen by the datapath, time values zero extended
   typedef struct packed {
      logic [31:0] expected_channel;
      logic [31:0] cal_version;
      logic [63:0] nominal;
      logic [63:0] timeout;
      logic [63:0] limit;
   } cfg_type;

   typedef struct packed {
      logic        operation;
      logic [31:0] channel_tag;
      logic [63:0] time_us;
      logic [2:0]  prior_hint;
   } req_type;

   typedef struct packed {
      logic        fault_abort;
      logic [63:0] sequence_number;
      logic [63:0] interval_us;
      logic [31:0] version_out;
      logic        channel_reject;
      logic        timing_fault;
      logic        stale_missing;
      logic [2:0]  failure_class;
      logic        class_assigned;
      logic [63:0] deadline_us;
   } rsp_type;

endpackage

@@ design/sip_csr.sv @@
// ----------------------------------------------------------------------------
// sip_csr
// configuration registers with precomputed timeout and clamp limit
// ----------------------------------------------------------------------------
module sip_csr #(
   parameter int TIME_WIDTH   = 64,
   parameter int CLAMP_FACTOR = 10
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [sip_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [sip_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [sip_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready,
   output sip_pkg::cfg_type               cfg
);

   localparam int MulW = TIME_WIDTH + 7;

   function automatic logic [TIME_WIDTH-1:0] sat_mul(input logic [TIME_WIDTH-1:0] a,
                                                      input logic [6:0] k);
      logic [MulW-1:0] p;
      begin
         p = MulW'(a) * MulW'(k);
         if (p[MulW-1:TIME_WIDTH] != '0) return '1;
         return p[TIME_WIDTH-1:0];
      end
   endfunction

   function automatic logic [TIME_WIDTH-1:0] eff_nom(input logic [63:0] v);
      logic [TIME_WIDTH-1:0] n;
      begin
         n = v[TIME_WIDTH-1:0];
         if (n == '0) return TIME_WIDTH'(1);
         return n;
      end
   endfunction

   logic [31:0]           expected_channel_ff;
   logic [63:0]           nominal_ff;
   logic [31:0]           cal_version_ff;
   logic [TIME_WIDTH-1:0] nom_eff_ff;
   logic [TIME_WIDTH-1:0] timeout_ff;
   logic [TIME_WIDTH-1:0] limit_ff;
   logic [TIME_WIDTH-1:0] nom_in;
   logic [1:0]            index;
   logic                  wr_en;

   assign csr_pready = 1'b1;
   assign index      = csr_paddr[4:3];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign nom_in     = eff_nom(csr_pwdata);

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_channel_ff <= '0;
         nominal_ff          <= sip_pkg::NOMINAL_RESET;
         cal_version_ff      <= '0;
         nom_eff_ff          <= eff_nom(sip_pkg::NOMINAL_RESET);
         timeout_ff          <= sat_mul(eff_nom(sip_pkg::NOMINAL_RESET), 7'd2);
         limit_ff            <= sat_mul(eff_nom(sip_pkg::NOMINAL_RESET), 7'(CLAMP_FACTOR));
      end else if (wr_en) begin
         unique case (index)
            sip_pkg::REG_EXPECTED_CHANNEL: begin
               expected_channel_ff <= csr_pwdata[31:0];
            end
            sip_pkg::REG_NOMINAL_INTERVAL: begin
               nominal_ff <= csr_pwdata;
               nom_eff_ff <= nom_in;
               timeout_ff <= sat_mul(nom_in, 7'd2);
               limit_ff   <= sat_mul(nom_in, 7'(CLAMP_FACTOR));
            end
            sip_pkg::REG_CAL_VERSION: begin
               cal_version_ff <= csr_pwdata[31:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (index)
         sip_pkg::REG_EXPECTED_CHANNEL: csr_prdata = 64'(expected_channel_ff);
         sip_pkg::REG_NOMINAL_INTERVAL: csr_prdata = nominal_ff;
         sip_pkg::REG_CAL_VERSION:      csr_prdata = 64'(cal_version_ff);
         default:                       csr_prdata = '0;
      endcase
   end

   assign cfg.expected_channel = expected_channel_ff;
   assign cfg.cal_version      = cal_version_ff;
   assign cfg.nominal          = 64'(nom_eff_ff);
   assign cfg.timeout          = 64'(timeout_ff);
   assign cfg.limit            = 64'(limit_ff);

endmodule

@@ design/sip_qualify.sv @@
// ----------------------------------------------------------------------------
// sip_qualify
// input register, qualification logic, channel state and result register
// ----------------------------------------------------------------------------
module sip_qualify #(
   parameter int TIME_WIDTH = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  sip_pkg::cfg_type cfg,
   input  logic             req_valid,
   output logic             req_ready,
   input  sip_pkg::req_type req_item,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output sip_pkg::rsp_type rsp_item
);

   logic                  in_valid_ff;
   sip_pkg::req_type      in_item_ff;
   logic                  out_valid_ff;
   sip_pkg::rsp_type      out_item_ff;
   logic [63:0]           next_seq_ff;
   logic [TIME_WIDTH-1:0] last_arrival_ff;
   logic                  armed_ff;
   logic [TIME_WIDTH-1:0] deadline_ff;

   logic                  move;
   sip_pkg::rsp_type      out_item_in;
   logic [63:0]           next_seq_in;
   logic [TIME_WIDTH-1:0] last_arrival_in;
   logic                  armed_in;
   logic [TIME_WIDTH-1:0] deadline_in;

   logic [TIME_WIDTH-1:0] now;
   logic [TIME_WIDTH-1:0] nom;
   logic [TIME_WIDTH-1:0] timeout;
   logic [TIME_WIDTH-1:0] limit;
   logic [TIME_WIDTH-1:0] delta;
   logic [TIME_WIDTH:0]   sum;
   logic [TIME_WIDTH-1:0] new_deadline;

   assign move      = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || move;
   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_item_ff;

   assign now          = in_item_ff.time_us[TIME_WIDTH-1:0];
   assign nom          = cfg.nominal[TIME_WIDTH-1:0];
   assign timeout      = cfg.timeout[TIME_WIDTH-1:0];
   assign limit        = cfg.limit[TIME_WIDTH-1:0];
   assign delta        = (now > last_arrival_ff) ? now - last_arrival_ff : '0;
   assign sum          = {1'b0, now} + {1'b0, timeout};
   assign new_deadline = sum[TIME_WIDTH] ? '1 : sum[TIME_WIDTH-1:0];

   always_comb begin
      next_seq_in     = next_seq_ff;
      last_arrival_in = last_arrival_ff;
      armed_in        = armed_ff;
      deadline_in     = deadline_ff;

      out_item_in                 = '0;
      out_item_in.version_out     = cfg.cal_version;
      out_item_in.sequence_number = next_seq_ff;
      out_item_in.failure_class   = in_item_ff.prior_hint;
      out_item_in.deadline_us     = 64'(new_deadline);

      if (in_item_ff.operation == sip_pkg::OP_TIMEOUT) begin
         next_seq_in                = next_seq_ff + 64'd1;
         deadline_in                = new_deadline;
         out_item_in.interval_us    = 64'(timeout);
         out_item_in.stale_missing  = 1'b1;
         out_item_in.failure_class  = sip_pkg::CLASS_STALE;
         out_item_in.class_assigned = 1'b1;
      end else if (in_item_ff.channel_tag != cfg.expected_channel) begin
         out_item_in.fault_abort     = 1'b1;
         out_item_in.channel_reject  = 1'b1;
         out_item_in.sequence_number = '0;
         out_item_in.version_out     = '0;
         out_item_in.deadline_us     = 64'(deadline_ff);
      end else begin
         next_seq_in             = next_seq_ff + 64'd1;
         last_arrival_in         = now;
         armed_in                = 1'b1;
         deadline_in             = new_deadline;
         out_item_in.interval_us = 64'(nom);
         if (armed_ff) begin
            if (delta == '0) begin
               out_item_in.timing_fault = 1'b1;
               if (in_item_ff.prior_hint == sip_pkg::CLASS_NONE) begin
                  out_item_in.failure_class  = sip_pkg::CLASS_INVALID;
                  out_item_in.class_assigned = 1'b1;
               end
            end else if (delta > limit) begin
               out_item_in.timing_fault = 1'b1;
               if (in_item_ff.prior_hint == sip_pkg::CLASS_NONE) begin
                  out_item_in.failure_class  = sip_pkg::CLASS_GAP;
                  out_item_in.class_assigned = 1'b1;
               end
            end else begin
               out_item_in.interval_us = 64'(delta);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
         next_seq_ff     <= '0;
         last_arrival_ff <= '0;
         armed_ff        <= 1'b0;
         deadline_ff     <= '0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (move) begin
            out_valid_ff    <= 1'b1;
            next_seq_ff     <= next_seq_in;
            last_arrival_ff <= last_arrival_in;
            armed_ff        <= armed_in;
            deadline_ff     <= deadline_in;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_item_ff <= req_item;
      end
      if (move) begin
         out_item_ff <= out_item_in;
      end
   end

endmodule

@@ design/sample_interval_qualifier.sv @@
// ----------------------------------------------------------------------------
// sample_interval_qualifier
// qualifies timestamped samples of one channel, flags timing anomalies and
// keeps a watchdog deadline
// path: an input transfer passes through the input register, then the result register
// throughput: one item per cycle while rsp_tready is high, set by the input and result registers
// reset: synchronous, clears sequence, arrival, armed flag and deadline;
// registers return to channel 0, nominal 1000, version 0
// ----------------------------------------------------------------------------
module sample_interval_qualifier #(
   parameter int TIME_WIDTH   = 64,
   parameter int CLAMP_FACTOR = 10
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [103:0]                   req_tdata,  // channel_tag, time_us, prior_hint
   input  logic [0:0]                     req_tuser,  // operation
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // fault_abort, sequence_number, interval_us, version_out, channel_reject,
   // timing_fault, stale_missing, failure_class, class_assigned, deadline_us
   output logic [231:0]                   rsp_tdata,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [sip_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [sip_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [sip_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);

   sip_pkg::cfg_type cfg;
   sip_pkg::req_type req_item;
   sip_pkg::rsp_type rsp_item;

   assign req_item.operation   = req_tuser[0];
   assign req_item.channel_tag = req_tdata[31:0];
   assign req_item.time_us     = req_tdata[95:32];
   assign req_item.prior_hint  = req_tdata[98:96];

   assign rsp_tdata[0]       = rsp_item.fault_abort;
   assign rsp_tdata[64:1]    = rsp_item.sequence_number;
   assign rsp_tdata[128:65]  = rsp_item.interval_us;
   assign rsp_tdata[160:129] = rsp_item.version_out;
   assign rsp_tdata[161]     = rsp_item.channel_reject;
   assign rsp_tdata[162]     = rsp_item.timing_fault;
   assign rsp_tdata[163]     = rsp_item.stale_missing;
   assign rsp_tdata[166:164] = rsp_item.failure_class;
   assign rsp_tdata[167]     = rsp_item.class_assigned;
   assign rsp_tdata[231:168] = rsp_item.deadline_us;

   sip_csr #(
      .TIME_WIDTH   (TIME_WIDTH),
      .CLAMP_FACTOR (CLAMP_FACTOR)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   sip_qualify #(
      .TIME_WIDTH (TIME_WIDTH)
   ) u_qualify (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_item  (req_item),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_item  (rsp_item)
   );

endmodule

@@ design/sip_checker.sv @@
// ----------------------------------------------------------------------------
// sip_checker
// port level checks of the sample interval qualifier
// ----------------------------------------------------------------------------
module sip_checker (
   input logic         clock,
   input logic         reset,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [231:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_tvalid)
      else $error("result valid right after reset");

   a_abort_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |->
         rsp_tdata[161] && rsp_tdata[64:1] == 64'd0 && !rsp_tdata[167])
      else $error("abort result with sequence or class");

   a_stale_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[163] |->
         rsp_tdata[166:164] == sip_pkg::CLASS_STALE && rsp_tdata[167] &&
         !rsp_tdata[162] && !rsp_tdata[0])
      else $error("timeout result malformed");

   a_assign_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[167] |-> rsp_tdata[162] || rsp_tdata[163])
      else $error("class assigned without anomaly or timeout");

endmodule

bind sample_interval_qualifier sip_checker u_sip_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
